>>> rtl/background_tile_pixel_fetch_macros.svh
// Assertion macros shared by the background tile pixel fetch checkers.
// Included by the checker file; depends on nothing else.
`ifndef BACKGROUND_TILE_PIXEL_FETCH_MACROS_SVH
`define BACKGROUND_TILE_PIXEL_FETCH_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BGTPF_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BGTPF_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bgtpf_pkg.sv
// Shared types, constants and helpers for the background tile pixel fetch.
// Used by every module of the block; depends on nothing.
package bgtpf_pkg;

  // Default screen size.
  localparam int unsigned ScreenWidthDef  = 160;
  localparam int unsigned ScreenHeightDef = 144;

  // Video memory layout: tile data rows below the maps, maps at the top.
  localparam int unsigned VramAddrW   = 13;
  localparam int unsigned MapAddrW    = 11;
  localparam int unsigned MapDepth    = 2048;
  localparam int unsigned RowAddrW    = 12;
  localparam int unsigned RowDepth    = 3072;
  localparam logic [1:0]  MapRegionHi = 2'b11;

  // Configuration register indexes.
  localparam int unsigned CfgIndexW = 3;
  localparam logic [CfgIndexW-1:0] CfgScrollX    = 3'd0;
  localparam logic [CfgIndexW-1:0] CfgScrollY    = 3'd1;
  localparam logic [CfgIndexW-1:0] CfgMapSelect  = 3'd2;
  localparam logic [CfgIndexW-1:0] CfgDataSelect = 3'd3;
  localparam logic [CfgIndexW-1:0] CfgBgPalette  = 3'd4;

  localparam logic [7:0] BgPaletteReset = 8'd39;

  // Fixed shade colors.
  localparam logic [23:0] RgbWhite     = 24'hE0F8D0;
  localparam logic [23:0] RgbLightGray = 24'h88C070;
  localparam logic [23:0] RgbDarkGray  = 24'h346856;
  localparam logic [23:0] RgbBlack     = 24'h081820;

  typedef enum logic {
    KIND_WRITE  = 1'b0,
    KIND_RENDER = 1'b1
  } item_kind_e;

  // Configuration register file contents.
  typedef struct packed {
    logic [7:0] scroll_x;
    logic [7:0] scroll_y;
    logic       map_select;
    logic       data_select;
    logic [7:0] bg_palette;
  } cfg_t;

  // One classified item waiting for the back end.
  typedef struct packed {
    item_kind_e           kind;
    logic [VramAddrW-1:0] wr_addr;
    logic [7:0]           wr_data;
    logic [7:0]           bg_x;
    logic [7:0]           bg_y;
  } queue_entry_t;

  function automatic logic [23:0] shade_to_rgb(input logic [1:0] shade);
    logic [23:0] rgb;
    case (shade)
      2'd0:    rgb = RgbWhite;
      2'd1:    rgb = RgbLightGray;
      2'd2:    rgb = RgbDarkGray;
      default: rgb = RgbBlack;
    endcase
    return rgb;
  endfunction

endpackage

>>> rtl/bgtpf_front.sv
// Front end: accepts items, drops off-screen renders and scrolls the rest.
// Depends on bgtpf_pkg; feeds bgtpf_queue.
module bgtpf_front import bgtpf_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = ScreenWidthDef,
  parameter int unsigned SCREEN_HEIGHT = ScreenHeightDef
) (
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 opcode_i,
  input  logic [VramAddrW-1:0] vram_offset_i,
  input  logic [7:0]           write_byte_i,
  input  logic [7:0]           pixel_x_i,
  input  logic [7:0]           pixel_y_i,
  input  cfg_t                 cfg_i,
  input  logic                 queue_full_i,
  output logic                 push_o,
  output queue_entry_t         entry_o
);

  logic on_screen;
  logic drop;

  // A render outside the screen is taken and forgotten.
  assign on_screen = ({1'b0, pixel_x_i} < 9'(SCREEN_WIDTH)) &&
                     ({1'b0, pixel_y_i} < 9'(SCREEN_HEIGHT));
  assign drop      = (item_kind_e'(opcode_i) == KIND_RENDER) && !on_screen;

  assign in_ready_o = !queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i && !drop;

  // Scroll into the background; the 8-bit sums wrap by themselves.
  always_comb begin
    entry_o.kind    = item_kind_e'(opcode_i);
    entry_o.wr_addr = vram_offset_i;
    entry_o.wr_data = write_byte_i;
    entry_o.bg_x    = pixel_x_i + cfg_i.scroll_x;
    entry_o.bg_y    = pixel_y_i + cfg_i.scroll_y;
  end

endmodule

>>> rtl/bgtpf_queue.sv
// Two-entry queue that decouples the front end from the back end.
// Depends on bgtpf_pkg for the entry type.
module bgtpf_queue import bgtpf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  queue_entry_t entry_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output queue_entry_t entry_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  queue_entry_t slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign entry_o = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

>>> rtl/bgtpf_back.sv
// Back end: video memory, tile map and tile row fetch, palette and color.
// Depends on bgtpf_pkg; fed by bgtpf_queue.
module bgtpf_back import bgtpf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfg_t         cfg_i,
  input  logic         entry_valid_i,
  input  queue_entry_t entry_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [1:0]   color_number_o,
  output logic [1:0]   shade_o,
  output logic [23:0]  rgb_o
);

  // Tile maps and the even and odd bytes of the tile data rows.
  logic [7:0] map_mem     [MapDepth];
  logic [7:0] data_lo_mem [RowDepth];
  logic [7:0] data_hi_mem [RowDepth];

  logic                advance;
  logic                is_write;
  logic                is_render;
  logic                map_region;
  logic [MapAddrW-1:0] map_rd_addr;
  logic [RowAddrW-1:0] row_rd_addr;

  logic       s1_valid_q;
  logic [7:0] s1_tile_q;
  logic [2:0] s1_line_q;
  logic [2:0] s1_fine_x_q;

  logic       s2_valid_q;
  logic [7:0] s2_lo_q;
  logic [7:0] s2_hi_q;
  logic [2:0] s2_fine_x_q;

  logic [1:0] color_d;
  logic [1:0] shade_d;
  logic       out_valid_q;
  logic [1:0] color_q;
  logic [1:0] shade_q;
  logic [23:0] rgb_q;

  // The whole pipeline moves when the output register is free or drained.
  assign advance   = !out_valid_q || out_ready_i;
  assign pop_o     = entry_valid_i && advance;
  assign is_write  = pop_o && (entry_i.kind == KIND_WRITE);
  assign is_render = pop_o && (entry_i.kind == KIND_RENDER);

  assign map_region  = (entry_i.wr_addr[VramAddrW-1 -: 2] == MapRegionHi);
  assign map_rd_addr = {cfg_i.map_select, entry_i.bg_y[7:3], entry_i.bg_x[7:3]};

  // Row index of the tile line: unsigned tiles from the bottom of memory,
  // signed tiles around the middle of the data area.
  always_comb begin
    if (cfg_i.data_select) begin
      row_rd_addr = {1'b0, s1_tile_q, s1_line_q};
    end else begin
      row_rd_addr = {~s1_tile_q[7], s1_tile_q, s1_line_q};
    end
  end

  // Tile map memory: writes into the map region, tile index reads.
  always_ff @(posedge clk_i) begin
    if (is_write && map_region) begin
      map_mem[entry_i.wr_addr[MapAddrW-1:0]] <= entry_i.wr_data;
    end
    if (advance) begin
      s1_tile_q <= map_mem[map_rd_addr];
    end
  end

  // Low bit plane bytes sit at even offsets.
  always_ff @(posedge clk_i) begin
    if (is_write && !map_region && !entry_i.wr_addr[0]) begin
      data_lo_mem[entry_i.wr_addr[VramAddrW-1:1]] <= entry_i.wr_data;
    end
    if (advance) begin
      s2_lo_q <= data_lo_mem[row_rd_addr];
    end
  end

  // High bit plane bytes sit at odd offsets.
  always_ff @(posedge clk_i) begin
    if (is_write && !map_region && entry_i.wr_addr[0]) begin
      data_hi_mem[entry_i.wr_addr[VramAddrW-1:1]] <= entry_i.wr_data;
    end
    if (advance) begin
      s2_hi_q <= data_hi_mem[row_rd_addr];
    end
  end

  // Position within the tile travels alongside the reads.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_line_q   <= entry_i.bg_y[2:0];
      s1_fine_x_q <= entry_i.bg_x[2:0];
      s2_fine_x_q <= s1_fine_x_q;
    end
  end

  // Pixel 0 of a tile row is the most significant bit.
  assign color_d = {s2_hi_q[~s2_fine_x_q], s2_lo_q[~s2_fine_x_q]};
  assign shade_d = cfg_i.bg_palette[{color_d, 1'b0} +: 2];

  always_ff @(posedge clk_i) begin
    if (advance) begin
      color_q <= color_d;
      shade_q <= shade_d;
      rgb_q   <= shade_to_rgb(shade_d);
    end
  end

  // Valid bits of the stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= is_render;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign color_number_o = color_q;
  assign shade_o        = shade_q;
  assign rgb_o          = rgb_q;

endmodule

>>> rtl/background_tile_pixel_fetch.sv
// Background tile pixel fetch, top level: configuration registers, front end,
// queue and back end. Depends on bgtpf_pkg, bgtpf_front, bgtpf_queue, bgtpf_back.
//
// The block keeps 8 KiB of video memory, filled by write items, and renders one
// background pixel per render item. It takes one item per clock as long as the
// result stream is not stalled. A taken render item passes through the two-entry
// queue, then the tile map read and the tile row read, each a registered read
// of its own memory, then the palette and color output register. The memory is
// split into the tile maps and the even and odd bytes of the tile data, so both
// bit planes are read in the same cycle. Writes and off-screen renders give no
// result. Memory is not cleared at reset; reading a byte that was never written
// returns an unknown value. Configuration registers must be written only while
// the block is idle; the block itself does not enforce this.
module background_tile_pixel_fetch import bgtpf_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = ScreenWidthDef,
  parameter int unsigned SCREEN_HEIGHT = ScreenHeightDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write channel.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [7:0]           cfg_data_i,
  // Item stream.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // tdata: vram_offset[12:0], write_byte[20:13], pixel_x[28:21],
  // pixel_y[36:29], zero [39:37]
  input  logic [39:0]          s_axis_tdata,
  // tuser: opcode[0]
  input  logic                 s_axis_tuser,
  // Result stream.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // tdata: color_number[1:0], shade[3:2], rgb[27:4], zero [31:28]
  output logic [31:0]          m_axis_tdata
);

  cfg_t         cfg_q;
  logic         queue_full;
  logic         push;
  queue_entry_t push_entry;
  logic         entry_valid;
  queue_entry_t pop_entry;
  logic         pop;
  logic [1:0]   color_number;
  logic [1:0]   shade;
  logic [23:0]  rgb;

  // Configuration registers; writes always complete at once.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scroll_x    <= '0;
      cfg_q.scroll_y    <= '0;
      cfg_q.map_select  <= 1'b0;
      cfg_q.data_select <= 1'b0;
      cfg_q.bg_palette  <= BgPaletteReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgScrollX:    cfg_q.scroll_x    <= cfg_data_i;
        CfgScrollY:    cfg_q.scroll_y    <= cfg_data_i;
        CfgMapSelect:  cfg_q.map_select  <= cfg_data_i[0];
        CfgDataSelect: cfg_q.data_select <= cfg_data_i[0];
        CfgBgPalette:  cfg_q.bg_palette  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Classify and scroll incoming items.
  bgtpf_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .opcode_i      (s_axis_tuser),
    .vram_offset_i (s_axis_tdata[12:0]),
    .write_byte_i  (s_axis_tdata[20:13]),
    .pixel_x_i     (s_axis_tdata[28:21]),
    .pixel_y_i     (s_axis_tdata[36:29]),
    .cfg_i         (cfg_q),
    .queue_full_i  (queue_full),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  bgtpf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (queue_full),
    .pop_i   (pop),
    .valid_o (entry_valid),
    .entry_o (pop_entry)
  );

  // Memory access and pixel color.
  bgtpf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .entry_valid_i  (entry_valid),
    .entry_i        (pop_entry),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .color_number_o (color_number),
    .shade_o        (shade),
    .rgb_o          (rgb)
  );

  assign m_axis_tdata = {4'b0, rgb, shade, color_number};

endmodule

>>> rtl/bgtpf_checker.sv
// Port-level checks for the background tile pixel fetch, bound to the top level.
// Depends on bgtpf_pkg and the shared assertion macros.
`include "background_tile_pixel_fetch_macros.svh"

module bgtpf_checker import bgtpf_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 cfg_valid_i,
  input logic                 cfg_ready_o,
  input logic [CfgIndexW-1:0] cfg_index_i,
  input logic [7:0]           cfg_data_i,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [39:0]          s_axis_tdata,
  input logic                 s_axis_tuser,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [31:0]          m_axis_tdata
);

  // A stalled result holds its value.
  `BGTPF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // The color always matches the shade that travels with it.
  `BGTPF_ASSERT_SAME(a_rgb_of_shade, clk_i, rst_ni, m_axis_tvalid, (m_axis_tdata[3:2] == 2'd0 && m_axis_tdata[27:4] == RgbWhite) || (m_axis_tdata[3:2] == 2'd1 && m_axis_tdata[27:4] == RgbLightGray) || (m_axis_tdata[3:2] == 2'd2 && m_axis_tdata[27:4] == RgbDarkGray) || (m_axis_tdata[3:2] == 2'd3 && m_axis_tdata[27:4] == RgbBlack), "rgb does not match shade")

  // Padding bits of a result are zero.
  `BGTPF_ASSERT_SAME(a_out_pad, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[31:28] == 4'b0, "result padding not zero")

  // Configuration writes never wait.
  `BGTPF_ASSERT_SAME(a_cfg_ready, clk_i, rst_ni, cfg_valid_i, cfg_ready_o, "configuration write stalled")

endmodule

bind background_tile_pixel_fetch bgtpf_checker u_checker (.*);

>>> sim/testbench.sv
// Self-checking testbench for the background tile pixel fetch block.
// Drives write and render transactions and register writes, and checks each pixel
// against a scoreboard that mirrors video memory. Depends on bgtpf_pkg and the RTL.
module testbench;
  import bgtpf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ScreenW      = 160;
  localparam int unsigned ScreenH      = 144;
  localparam int unsigned VramDepth    = 1 << VramAddrW;
  localparam int unsigned SettleCycles = 10;

  // Byte offsets of the tile maps and of the signed tile data areas.
  localparam logic [VramAddrW-1:0] MapLowBase    = 13'h1800;
  localparam logic [VramAddrW-1:0] MapHighBase   = 13'h1C00;
  localparam logic [VramAddrW-1:0] SignedBase    = 13'h1000;
  localparam logic [VramAddrW-1:0] SignedNegBase = 13'h0800;

  localparam logic [23:0] ShadeRgb [4] = '{24'hE0F8D0, 24'h88C070, 24'h346856, 24'h081820};

  typedef struct {
    logic [1:0]  color;
    logic [1:0]  shade;
    logic [23:0] rgb;
  } pixel_t;

  // Mirror of video memory and registers, with the queue of pixels still owed.
  class pixel_ledger;
    logic [7:0] vram [VramDepth];
    bit         filled [VramDepth];
    logic [7:0] scroll_x;
    logic [7:0] scroll_y;
    logic       map_select;
    logic       data_select;
    logic [7:0] bg_palette;
    pixel_t     pending_pixels [$];
    int         mismatches;

    function new();
      scroll_x    = '0;
      scroll_y    = '0;
      map_select  = 1'b0;
      data_select = 1'b0;
      bg_palette  = BgPaletteReset;
      mismatches  = 0;
    endfunction

    function void set_reg(logic [CfgIndexW-1:0] idx, logic [7:0] data);
      case (idx)
        CfgScrollX:    scroll_x    = data;
        CfgScrollY:    scroll_y    = data;
        CfgMapSelect:  map_select  = data[0];
        CfgDataSelect: data_select = data[0];
        CfgBgPalette:  bg_palette  = data;
        default: ;
      endcase
    endfunction

    // Tile map entry that covers the scrolled background point.
    function logic [VramAddrW-1:0] map_addr_of(logic [7:0] px, logic [7:0] py);
      logic [7:0] bx;
      logic [7:0] by;
      bx = px + scroll_x;
      by = py + scroll_y;
      return (map_select ? MapHighBase : MapLowBase) + {by[7:3], bx[7:3]};
    endfunction

    // Address of the low bit-plane byte of the tile row under the point.
    function logic [VramAddrW-1:0] row_addr_of(logic [7:0] px, logic [7:0] py);
      logic [7:0]           tile;
      logic [7:0]           by;
      logic [VramAddrW-1:0] base;
      tile = vram[map_addr_of(px, py)];
      by   = py + scroll_y;
      if (data_select) begin
        base = {1'b0, tile, 4'b0000};
      end else if (tile[7]) begin
        base = SignedNegBase + {tile[6:0], 4'b0000};
      end else begin
        base = SignedBase + {tile[6:0], 4'b0000};
      end
      return base + {by[2:0], 1'b0};
    endfunction

    // Called for every accepted input transaction.
    function void note_item(item_kind_e kind, logic [VramAddrW-1:0] ofs, logic [7:0] data,
                            logic [7:0] px, logic [7:0] py);
      logic [VramAddrW-1:0] row;
      logic [7:0]           bx;
      logic [7:0]           lo;
      logic [7:0]           hi;
      logic [2:0]           pos;
      pixel_t               pix;
      if (kind == KIND_WRITE) begin
        vram[ofs]   = data;
        filled[ofs] = 1'b1;
        return;
      end
      // Off-screen renders produce nothing.
      if (px >= ScreenW || py >= ScreenH) return;
      bx        = px + scroll_x;
      row       = row_addr_of(px, py);
      lo        = vram[row];
      hi        = vram[row + 13'd1];
      pos       = 3'd7 - bx[2:0];
      pix.color = {hi[pos], lo[pos]};
      pix.shade = bg_palette[{pix.color, 1'b0} +: 2];
      pix.rgb   = ShadeRgb[pix.shade];
      pending_pixels.push_back(pix);
    endfunction

    // Called for every accepted result transaction.
    function void check_pixel(logic [31:0] word);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        $error("result with no pixel pending: tdata %h", word);
        mismatches++;
        return;
      end
      want = pending_pixels.pop_front();
      if (word[1:0] !== want.color) begin
        $error("color_number: expected %0d, actual %0d", want.color, word[1:0]);
        mismatches++;
      end
      if (word[3:2] !== want.shade) begin
        $error("shade: expected %0d, actual %0d", want.shade, word[3:2]);
        mismatches++;
      end
      if (word[27:4] !== want.rgb) begin
        $error("rgb: expected %h, actual %h", want.rgb, word[27:4]);
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i   = '0;
  logic [7:0]           cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [39:0]          s_axis_tdata  = '0;
  logic                 s_axis_tuser  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [31:0]          m_axis_tdata;

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          items_sent     = 0;
  pixel_ledger ledger         = new();

  background_tile_pixel_fetch #(
    .SCREEN_WIDTH (ScreenW),
    .SCREEN_HEIGHT(ScreenH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Result side: check each accepted transaction, then pick the next ready.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) ledger.check_pixel(m_axis_tdata);
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Sends one item and returns at the edge that accepts it, tvalid still high.
  task automatic send_item(item_kind_e kind, logic [VramAddrW-1:0] ofs, logic [7:0] data,
                           logic [7:0] px, logic [7:0] py);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {3'b000, py, px, data, ofs};
    do @(posedge clk_i); while (!s_axis_tready);
    ledger.note_item(kind, ofs, data, px, py);
    items_sent++;
  endtask

  task automatic send_write(logic [VramAddrW-1:0] ofs, logic [7:0] data);
    send_item(KIND_WRITE, ofs, data, 8'($urandom), 8'($urandom));
  endtask

  task automatic fill_if_blank(logic [VramAddrW-1:0] addr);
    if (!ledger.filled[addr]) send_write(addr, 8'($urandom));
  endtask

  // A render first writes any byte it would read that was never written.
  task automatic render_pixel(logic [7:0] px, logic [7:0] py);
    logic [VramAddrW-1:0] row;
    if (px < ScreenW && py < ScreenH) begin
      fill_if_blank(ledger.map_addr_of(px, py));
      row = ledger.row_addr_of(px, py);
      fill_if_blank(row);
      fill_if_blank(row + 13'd1);
    end
    send_item(KIND_RENDER, 13'($urandom), 8'($urandom), px, py);
  endtask

  // Stops sending, waits for every owed pixel, then lets the pipeline settle.
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (ledger.pending_pixels.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [CfgIndexW-1:0] idx, logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    ledger.set_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // One-bit registers get random upper bits, which the block must drop.
  task automatic apply_setup(logic [7:0] sx, logic [7:0] sy, logic ms, logic ds,
                             logic [7:0] pal);
    quiesce();
    write_cfg(CfgScrollX, sx);
    write_cfg(CfgScrollY, sy);
    write_cfg(CfgMapSelect, {7'($urandom), ms});
    write_cfg(CfgDataSelect, {7'($urandom), ds});
    write_cfg(CfgBgPalette, pal);
  endtask

  // Random mix of writes and renders; count covers every transaction sent, fills too.
  task automatic run_random(int count);
    int         start;
    logic [7:0] px;
    logic [7:0] py;
    start = items_sent;
    while (items_sent - start < count) begin
      if ($urandom_range(99) < 40) begin
        if ($urandom_range(99) < 30) begin
          send_write(MapLowBase + 13'($urandom_range(2047)), 8'($urandom));
        end else begin
          send_write(13'($urandom), 8'($urandom));
        end
      end else begin
        px = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(ScreenW - 1));
        py = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(ScreenH - 1));
        render_pixel(px, py);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extreme offsets and bytes, signed tiles on both sides of 128.
    send_write(13'h0000, 8'h00);
    send_write(13'h1FFF, 8'hFF);
    send_write(MapLowBase, 8'h80);
    send_write(MapLowBase + 13'd1, 8'h7F);
    render_pixel(8'd0, 8'd0);
    render_pixel(8'd8, 8'd0);
    render_pixel(8'(ScreenW - 1), 8'(ScreenH - 1));
    render_pixel(8'(ScreenW - 1), 8'd0);
    render_pixel(8'd0, 8'(ScreenH - 1));
    // Off-screen renders must be dropped.
    render_pixel(8'(ScreenW), 8'd0);
    render_pixel(8'd0, 8'(ScreenH));
    render_pixel(8'hFF, 8'hFF);
    quiesce();
    // Indexes past the register list must change nothing.
    for (int i = int'(CfgBgPalette) + 1; i < (1 << CfgIndexW); i++) begin
      write_cfg(CfgIndexW'(i), 8'hFF);
    end
    render_pixel(8'd3, 8'd5);
    // Maximum scroll wraps the background in both directions.
    apply_setup(8'hFF, 8'hFF, 1'b1, 1'b1, 8'hE4);
    render_pixel(8'd0, 8'd0);
    render_pixel(8'd1, 8'd1);
    render_pixel(8'(ScreenW - 1), 8'(ScreenH - 1));

    // Random phases under different settings and handshake pressure.
    apply_setup(8'h00, 8'h00, 1'b0, 1'b1, 8'hE4);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(250);

    apply_setup(8'hFF, 8'hFF, 1'b1, 1'b0, 8'h1B);
    send_idle_pct  = 60;
    recv_stall_pct = 0;
    run_random(250);

    apply_setup(8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom), 8'h00);
    send_idle_pct  = 0;
    recv_stall_pct = 60;
    run_random(125);
    quiesce();
    run_random(125);

    apply_setup(8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom), 8'hFF);
    send_idle_pct  = 24;
    recv_stall_pct = 24;
    run_random(250);

    apply_setup(8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(250);

    quiesce();
    if (ledger.mismatches == 0 && ledger.pending_pixels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
